@@ rtl/core/sccb_pkg.sv @@
`timescale 1ns / 1ps
// Shared codes and types for the SCCB register access sequencer.
// No dependencies; used by sccb_register_access_sequencer_core.
package sccb_pkg;

  localparam logic [1:0] ACT_WRITE  = 2'd0;
  localparam logic [1:0] ACT_READ   = 2'd1;
  localparam logic [1:0] ACT_STATUS = 2'd2;

  localparam logic [2:0] CMD_NONE       = 3'd0;
  localparam logic [2:0] CMD_START      = 3'd1;
  localparam logic [2:0] CMD_SEND       = 3'd2;
  localparam logic [2:0] CMD_RECV_NACK  = 3'd3;
  localparam logic [2:0] CMD_STOP       = 3'd4;
  localparam logic [2:0] CMD_STOP_START = 3'd5;

  localparam logic [7:0] ST_START        = 8'h08;
  localparam logic [7:0] ST_MT_SLA_ACK   = 8'h18;
  localparam logic [7:0] ST_MT_SLA_NACK  = 8'h20;
  localparam logic [7:0] ST_MT_DATA_ACK  = 8'h28;
  localparam logic [7:0] ST_MT_DATA_NACK = 8'h30;
  localparam logic [7:0] ST_MR_SLA_ACK   = 8'h40;
  localparam logic [7:0] ST_MR_SLA_NACK  = 8'h48;
  localparam logic [7:0] ST_MR_DATA_NACK = 8'h58;

  localparam logic [6:0] DEV_ADDR_RESET = 7'd33;

  typedef struct packed {
    logic [2:0] bus_cmd;
    logic [7:0] tx_byte;
    logic [7:0] read_data;
    logic       done_res;
    logic       busy_res;
    logic       rejected;
  } result_t;

endpackage

@@ rtl/core/sccb_register_access_sequencer_core.sv @@
`timescale 1ns / 1ps
// Top level of the SCCB register access sequencer: decode, state and output buffer.
// Depends on sccb_pkg.
//
// Each request (write, read or bus status event) is accepted while in_stall is
// low and its single result is registered, so the block sustains one request
// per clock unless stalled. The decode of one request against the
// transaction state is a small piece of logic between the input handshake and
// the output register. A two-entry output buffer (output register plus one skid
// entry) keeps input flowing while a result waits; in_stall rises only when
// both entries hold results that downstream has not taken. device_address may
// be written at any time the block is idle and takes effect on the next request.
module sccb_register_access_sequencer_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [6:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] action,
  input  logic [7:0] reg_addr,
  input  logic [7:0] reg_data,
  input  logic [7:0] bus_status,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] bus_cmd,
  output logic [7:0] tx_byte,
  output logic [7:0] read_data,
  output logic       done_res,
  output logic       busy_res,
  output logic       rejected
);

  logic [6:0] device_address;
  logic       first_phase, first_phase_next;
  logic       is_write, is_write_next;
  logic       in_progress, in_progress_next;
  logic [7:0] held_register, held_register_next;
  logic [7:0] held_data, held_data_next;

  sccb_pkg::result_t res_next;
  sccb_pkg::result_t out_res;
  sccb_pkg::result_t skid_res;
  logic              skid_valid;
  logic              accept;
  logic              out_take;

  assign in_stall = skid_valid;
  assign accept   = in_valid && !skid_valid;
  assign out_take = out_valid && !out_stall;

  always_comb begin
    first_phase_next   = first_phase;
    is_write_next      = is_write;
    in_progress_next   = in_progress;
    held_register_next = held_register;
    held_data_next     = held_data;
    res_next           = '0;
    if (action == sccb_pkg::ACT_WRITE || action == sccb_pkg::ACT_READ) begin
      if (in_progress) begin
        res_next.rejected = 1'b1;
      end else begin
        held_register_next = reg_addr;
        if (action == sccb_pkg::ACT_WRITE) begin
          held_data_next = reg_data;
        end
        is_write_next    = (action == sccb_pkg::ACT_WRITE);
        first_phase_next = 1'b1;
        in_progress_next = 1'b1;
        res_next.bus_cmd = sccb_pkg::CMD_START;
      end
    end else if (action == sccb_pkg::ACT_STATUS && in_progress) begin
      case (bus_status)
        sccb_pkg::ST_START: begin
          res_next.bus_cmd = sccb_pkg::CMD_SEND;
          res_next.tx_byte = {device_address, !(first_phase || is_write)};
        end
        sccb_pkg::ST_MT_SLA_ACK: begin
          res_next.bus_cmd = sccb_pkg::CMD_SEND;
          res_next.tx_byte = held_register;
        end
        sccb_pkg::ST_MT_DATA_ACK: begin
          if (first_phase && is_write) begin
            first_phase_next = 1'b0;
            res_next.bus_cmd = sccb_pkg::CMD_SEND;
            res_next.tx_byte = held_data;
          end else if (is_write) begin
            res_next.bus_cmd  = sccb_pkg::CMD_STOP;
            in_progress_next  = 1'b0;
            res_next.done_res = 1'b1;
          end else begin
            first_phase_next = 1'b0;
            res_next.bus_cmd = sccb_pkg::CMD_STOP_START;
          end
        end
        sccb_pkg::ST_MR_SLA_ACK: begin
          res_next.bus_cmd = sccb_pkg::CMD_RECV_NACK;
        end
        sccb_pkg::ST_MR_DATA_NACK: begin
          held_data_next    = rx_byte;
          res_next.bus_cmd  = sccb_pkg::CMD_STOP;
          in_progress_next  = 1'b0;
          res_next.done_res = 1'b1;
        end
        sccb_pkg::ST_MT_DATA_NACK, sccb_pkg::ST_MT_SLA_NACK: begin
          res_next.bus_cmd = sccb_pkg::CMD_STOP_START;
          first_phase_next = 1'b1;
        end
        sccb_pkg::ST_MR_SLA_NACK: begin
          res_next.bus_cmd  = sccb_pkg::CMD_STOP;
          in_progress_next  = 1'b0;
          res_next.done_res = 1'b1;
        end
        default: begin
        end
      endcase
      if (res_next.done_res && !is_write) begin
        res_next.read_data = held_data_next;
      end
    end
    res_next.busy_res = in_progress_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= sccb_pkg::DEV_ADDR_RESET;
    end else if (cfg_we) begin
      device_address <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_phase   <= 1'b0;
      is_write      <= 1'b0;
      in_progress   <= 1'b0;
      held_register <= '0;
      held_data     <= '0;
    end else if (accept) begin
      first_phase   <= first_phase_next;
      is_write      <= is_write_next;
      in_progress   <= in_progress_next;
      held_register <= held_register_next;
      held_data     <= held_data_next;
    end
  end

  // output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_take || !out_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (accept) begin
      if (out_take || !out_valid) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_take || !out_valid) begin
        out_res <= skid_res;
      end
    end else if (accept) begin
      if (out_take || !out_valid) begin
        out_res <= res_next;
      end else begin
        skid_res <= res_next;
      end
    end
  end

  assign bus_cmd   = out_res.bus_cmd;
  assign tx_byte   = out_res.tx_byte;
  assign read_data = out_res.read_data;
  assign done_res  = out_res.done_res;
  assign busy_res  = out_res.busy_res;
  assign rejected  = out_res.rejected;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry holds a result while the output register is empty");

  a_done_clears_busy: assert property (@(posedge clk) disable iff (rst)
    accept && res_next.done_res |=> !in_progress)
    else $error("transaction still active after a finishing request");

  a_reject_no_cmd: assert property (@(posedge clk) disable iff (rst)
    out_valid && rejected |-> bus_cmd == sccb_pkg::CMD_NONE && busy_res)
    else $error("rejected request produced a bus command or idle status");

  a_busy_tracks_state: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_progress == $past(res_next.busy_res))
    else $error("busy flag disagrees with transaction state");

  a_start_only_idle: assert property (@(posedge clk) disable iff (rst)
    accept && res_next.bus_cmd == sccb_pkg::CMD_START |-> !in_progress)
    else $error("start issued during an active transaction");

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for sccb_register_access_sequencer_core.
// Depends on sccb_pkg and the core RTL; predicts each result in SystemVerilog and
// compares it against the core output under random sender gaps and receiver stalls.
module tb;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEMS_PER_PHASE = 650;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [6:0] cfg_data = '0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] action = '0;
  logic [7:0] reg_addr = '0;
  logic [7:0] reg_data = '0;
  logic [7:0] bus_status = '0;
  logic [7:0] rx_byte = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [2:0] bus_cmd;
  logic [7:0] tx_byte;
  logic [7:0] read_data;
  logic       done_res;
  logic       busy_res;
  logic       rejected;

  sccb_register_access_sequencer_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .reg_addr  (reg_addr),
    .reg_data  (reg_data),
    .bus_status(bus_status),
    .rx_byte   (rx_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .bus_cmd   (bus_cmd),
    .tx_byte   (tx_byte),
    .read_data (read_data),
    .done_res  (done_res),
    .busy_res  (busy_res),
    .rejected  (rejected)
  );

  // sequencer state as predicted
  logic [6:0] dev_addr_model = sccb_pkg::DEV_ADDR_RESET;
  logic       xfer_first = 1'b0;
  logic       xfer_write = 1'b0;
  logic       xfer_active = 1'b0;
  logic [7:0] xfer_reg = '0;
  logic [7:0] xfer_data = '0;

  sccb_pkg::result_t expected_cmds[$];
  sccb_pkg::result_t want_res;
  sccb_pkg::result_t got_res;
  int      mismatch_count = 0;
  int      cycle_count = 0;
  int      src_idle_pct = 0;
  int      dst_stall_pct = 0;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic sccb_pkg::result_t next_bus_cmd(input logic [1:0] act,
                                                     input logic [7:0] ra,
                                                     input logic [7:0] rd,
                                                     input logic [7:0] st,
                                                     input logic [7:0] rx);
    sccb_pkg::result_t r;
    r = '0;
    if (act == sccb_pkg::ACT_WRITE || act == sccb_pkg::ACT_READ) begin
      if (xfer_active) begin
        r.rejected = 1'b1;
      end else begin
        xfer_reg = ra;
        if (act == sccb_pkg::ACT_WRITE) begin
          xfer_data = rd;
        end
        xfer_write = (act == sccb_pkg::ACT_WRITE);
        xfer_first = 1'b1;
        xfer_active = 1'b1;
        r.bus_cmd = sccb_pkg::CMD_START;
      end
    end else if (act == sccb_pkg::ACT_STATUS && xfer_active) begin
      case (st)
        sccb_pkg::ST_START: begin
          r.bus_cmd = sccb_pkg::CMD_SEND;
          r.tx_byte = {dev_addr_model, ~(xfer_first | xfer_write)};
        end
        sccb_pkg::ST_MT_SLA_ACK: begin
          r.bus_cmd = sccb_pkg::CMD_SEND;
          r.tx_byte = xfer_reg;
        end
        sccb_pkg::ST_MT_DATA_ACK: begin
          if (xfer_first && xfer_write) begin
            xfer_first = 1'b0;
            r.bus_cmd = sccb_pkg::CMD_SEND;
            r.tx_byte = xfer_data;
          end else if (xfer_write) begin
            r.bus_cmd = sccb_pkg::CMD_STOP;
            xfer_active = 1'b0;
            r.done_res = 1'b1;
          end else begin
            xfer_first = 1'b0;
            r.bus_cmd = sccb_pkg::CMD_STOP_START;
          end
        end
        sccb_pkg::ST_MR_SLA_ACK: begin
          r.bus_cmd = sccb_pkg::CMD_RECV_NACK;
        end
        sccb_pkg::ST_MR_DATA_NACK: begin
          xfer_data = rx;
          r.bus_cmd = sccb_pkg::CMD_STOP;
          xfer_active = 1'b0;
          r.done_res = 1'b1;
        end
        sccb_pkg::ST_MT_DATA_NACK, sccb_pkg::ST_MT_SLA_NACK: begin
          r.bus_cmd = sccb_pkg::CMD_STOP_START;
          xfer_first = 1'b1;
        end
        sccb_pkg::ST_MR_SLA_NACK: begin
          r.bus_cmd = sccb_pkg::CMD_STOP;
          xfer_active = 1'b0;
          r.done_res = 1'b1;
        end
        default: begin
        end
      endcase
      if (r.done_res && !xfer_write) begin
        r.read_data = xfer_data;
      end
    end
    r.busy_res = xfer_active;
    return r;
  endfunction

  task automatic note_mismatch(input string what, input sccb_pkg::result_t want,
                               input sccb_pkg::result_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t %s: expected cmd=%0d tx=%02h rd=%02h done=%0b busy=%0b rej=%0b",
               $time, what, want.bus_cmd, want.tx_byte, want.read_data, want.done_res,
               want.busy_res, want.rejected);
      $display("%0t %s: actual   cmd=%0d tx=%02h rd=%02h done=%0b busy=%0b rej=%0b",
               $time, what, got.bus_cmd, got.tx_byte, got.read_data, got.done_res,
               got.busy_res, got.rejected);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && cfg_we) begin
      dev_addr_model = cfg_data;
    end
    if (!rst && in_valid && !in_stall) begin
      expected_cmds.push_back(next_bus_cmd(action, reg_addr, reg_data, bus_status, rx_byte));
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      got_res = '{bus_cmd, tx_byte, read_data, done_res, busy_res, rejected};
      if (expected_cmds.size() == 0) begin
        note_mismatch("unexpected result", '0, got_res);
      end else begin
        want_res = expected_cmds.pop_front();
        if (got_res !== want_res) begin
          note_mismatch("result mismatch", want_res, got_res);
        end
      end
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < dst_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_req(input logic [1:0] act, input logic [7:0] ra, input logic [7:0] rd,
                          input logic [7:0] st, input logic [7:0] rx);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    action     <= act;
    reg_addr   <= ra;
    reg_data   <= rd;
    bus_status <= st;
    rx_byte    <= rx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_event(input logic [7:0] st, input logic [7:0] rx);
    send_req(sccb_pkg::ACT_STATUS, 8'($urandom), 8'($urandom), st, rx);
  endtask

  // hold off until every expected result has come
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_cmds.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_device_address(input logic [6:0] addr);
    drain();
    if (xfer_active) begin
      send_event(sccb_pkg::ST_MR_SLA_NACK, 8'($urandom));
      drain();
    end
    cfg_we   <= 1'b1;
    cfg_data <= addr;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_noise(inout int n_sent);
    logic [7:0] junk;
    junk = 8'($urandom);
    case ($urandom_range(3))
      0: send_req(2'($urandom_range(1)), 8'($urandom), 8'($urandom), 8'($urandom),
                  8'($urandom));
      1: begin
        if (junk[2:0] == 3'd0) begin
          junk[0] = 1'b1;
        end
        send_event(junk, 8'($urandom));
      end
      2: send_event(8'h10, 8'($urandom));
      default: send_req(ACT_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom),
                        8'($urandom));
    endcase
    n_sent++;
  endtask

  task automatic send_step(input logic [7:0] st, inout int n_sent);
    if ($urandom_range(99) < 6) begin
      send_noise(n_sent);
    end
    send_event(st, 8'($urandom));
    n_sent++;
  endtask

  task automatic run_transaction(inout int n_sent);
    logic is_wr;
    logic finished;
    is_wr = 1'($urandom_range(1));
    finished = 1'b0;
    send_req(is_wr ? sccb_pkg::ACT_WRITE : sccb_pkg::ACT_READ, 8'($urandom), 8'($urandom),
             8'($urandom), 8'($urandom));
    n_sent++;
    while (!finished) begin
      send_step(sccb_pkg::ST_START, n_sent);
      if ($urandom_range(99) < 8) begin
        send_step(sccb_pkg::ST_MT_SLA_NACK, n_sent);
        continue;
      end
      send_step(sccb_pkg::ST_MT_SLA_ACK, n_sent);
      if ($urandom_range(99) < 8) begin
        send_step(sccb_pkg::ST_MT_DATA_NACK, n_sent);
        continue;
      end
      send_step(sccb_pkg::ST_MT_DATA_ACK, n_sent);
      if (is_wr) begin
        if ($urandom_range(99) < 8) begin
          send_step(sccb_pkg::ST_MT_DATA_NACK, n_sent);
          continue;
        end
        send_step(sccb_pkg::ST_MT_DATA_ACK, n_sent);
        finished = 1'b1;
      end else begin
        if ($urandom_range(99) < 10) begin
          send_step(sccb_pkg::ST_MT_DATA_ACK, n_sent);
        end
        send_step(sccb_pkg::ST_START, n_sent);
        if ($urandom_range(99) < 10) begin
          send_step(sccb_pkg::ST_MR_SLA_NACK, n_sent);
        end else begin
          send_step(sccb_pkg::ST_MR_SLA_ACK, n_sent);
          send_step(sccb_pkg::ST_MR_DATA_NACK, n_sent);
        end
        finished = 1'b1;
      end
    end
  endtask

  task automatic run_traffic(input int n_items);
    int n_sent;
    n_sent = 0;
    while (n_sent < n_items) begin
      if ($urandom_range(99) < 15) begin
        // status event with no transaction open, or an unused action
        if ($urandom_range(1)) begin
          send_event(8'($urandom), 8'($urandom));
        end else begin
          send_req(ACT_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        end
        n_sent++;
      end else begin
        run_transaction(n_sent);
      end
      if ($urandom_range(99) < 2) begin
        drain();
      end
    end
  endtask

  task automatic test_write_and_read();
    send_req(sccb_pkg::ACT_WRITE, 8'hFF, 8'h00, 8'h00, 8'h00);
    send_event(sccb_pkg::ST_START, 8'h00);
    send_event(sccb_pkg::ST_MT_SLA_ACK, 8'h00);
    send_event(sccb_pkg::ST_MT_DATA_ACK, 8'h00);
    send_event(sccb_pkg::ST_MT_DATA_ACK, 8'h00);
    send_req(sccb_pkg::ACT_READ, 8'h00, 8'hFF, 8'hFF, 8'hFF);
    send_req(sccb_pkg::ACT_WRITE, 8'hAA, 8'h55, 8'h00, 8'h00);
    send_event(sccb_pkg::ST_START, 8'h00);
    send_event(sccb_pkg::ST_MT_SLA_ACK, 8'h00);
    send_event(sccb_pkg::ST_MT_DATA_ACK, 8'h00);
    send_event(sccb_pkg::ST_START, 8'h00);
    send_event(sccb_pkg::ST_MR_SLA_ACK, 8'h00);
    send_event(sccb_pkg::ST_MR_DATA_NACK, 8'hA5);
  endtask

  task automatic test_special_cases();
    send_event(sccb_pkg::ST_START, 8'hFF);
    send_req(ACT_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_req(sccb_pkg::ACT_READ, 8'h55, 8'h00, 8'h00, 8'h00);
    send_event(8'h10, 8'h00);
    send_event(sccb_pkg::ST_MT_SLA_NACK, 8'h00);
    send_event(sccb_pkg::ST_START, 8'h00);
    send_event(sccb_pkg::ST_MT_SLA_ACK, 8'h00);
    send_event(sccb_pkg::ST_MT_DATA_ACK, 8'h00);
    send_event(sccb_pkg::ST_MT_DATA_ACK, 8'h00);
    send_event(sccb_pkg::ST_START, 8'h00);
    send_event(sccb_pkg::ST_MR_SLA_NACK, 8'h00);
    send_req(sccb_pkg::ACT_WRITE, 8'h3C, 8'hFF, 8'h00, 8'h00);
    send_event(sccb_pkg::ST_START, 8'h00);
    send_event(sccb_pkg::ST_MT_DATA_NACK, 8'h00);
  endtask

  task automatic test_device_address_extremes();
    set_device_address(7'd0);
    run_traffic(20);
    set_device_address(7'd127);
    run_traffic(20);
  endtask

  task automatic test_random_traffic();
    src_idle_pct  = 6;
    dst_stall_pct = 52;
    set_device_address(7'($urandom));
    run_traffic(ITEMS_PER_PHASE);
    src_idle_pct  = 52;
    dst_stall_pct = 6;
    set_device_address(7'd127);
    run_traffic(ITEMS_PER_PHASE);
    src_idle_pct  = 0;
    dst_stall_pct = 0;
    set_device_address(7'($urandom));
    run_traffic(ITEMS_PER_PHASE);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_write_and_read();
    test_special_cases();
    test_device_address_extremes();
    test_random_traffic();
    drain();
    mismatch_count += expected_cmds.size();
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
